### hw/rtl/line_loss_recovery_controller_unit_assert.svh
// Assertion macros for the line loss recovery controller.
// Each use expects clk and rst in scope; nothing else is required.
`ifndef LINE_LOSS_RECOVERY_CONTROLLER_UNIT_ASSERT_SVH
`define LINE_LOSS_RECOVERY_CONTROLLER_UNIT_ASSERT_SVH

// The condition must never hold outside reset.
`define LLRC_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define LLRC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LLRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/llrc_pkg.sv
// Shared types and constants for the line loss recovery controller.
// No dependencies; used by line_loss_recovery_controller_unit.
`default_nettype none

package llrc_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int ADC_W       = 12;
  localparam logic [ADC_W-1:0] SAMPLE_MASK =
      (SAMPLE_BITS >= ADC_W) ? {ADC_W{1'b1}} : ADC_W'((1 << SAMPLE_BITS) - 1);

  // Result queue geometry.
  localparam int QDEPTH = 4;
  localparam int PTR_W  = 2;
  localparam int CNT_W  = 3;

  // Register map, indexed by paddr[4:2].
  localparam logic [2:0] REG_LOW_TH    = 3'd0;
  localparam logic [2:0] REG_HIGH_TH   = 3'd1;
  localparam logic [2:0] REG_BASE_STEER = 3'd2;
  localparam logic [2:0] REG_TURN_DRIVE = 3'd3;
  localparam logic [2:0] REG_REVERSE_PWM = 3'd4;
  localparam logic [2:0] REG_CRAWL_SPEED = 3'd5;

  localparam logic [11:0] LOW_TH_RST      = 12'd600;
  localparam logic [11:0] HIGH_TH_RST     = 12'd3000;
  localparam logic [8:0]  BASE_STEER_RST  = 9'd220;
  localparam logic [7:0]  TURN_DRIVE_RST  = 8'd50;
  localparam logic [7:0]  REVERSE_PWM_RST = 8'd130;
  localparam logic [7:0]  CRAWL_SPEED_RST = 8'd20;

  localparam logic [9:0] FIRST_WIN_RST  = 10'd220;
  localparam logic [9:0] SECOND_WIN_RST = 10'd280;
  localparam logic [9:0] SECOND_OFFSET  = 10'd60;
  localparam logic [10:0] ESC_STEP      = 11'd70;
  localparam logic [10:0] FIRST_WIN_MAX = 11'd500;
  localparam logic [10:0] SECOND_WIN_MAX = 11'd520;
  localparam logic [1:0] COUNT_SAT      = 2'd3;

  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_POLL = 1'b1;

  typedef enum logic [1:0] {
    CMD_CRAWL   = 2'd0,
    CMD_STOP    = 2'd1,
    CMD_REVERSE = 2'd2,
    CMD_TURN    = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t       command;
    logic       turn_right;
    logic [7:0] drive_pwm;
    logic [7:0] speed_target;
    logic [9:0] window_ms;
    logic       line_found;
    logic       last_of_run;
  } result_t;

endpackage

`default_nettype wire

### hw/rtl/line_loss_recovery_controller_unit.sv
// Line loss recovery controller: hysteresis line flag, search sequencing, result queue.
// Depends on llrc_pkg and line_loss_recovery_controller_unit_assert.svh.
// Results are registered into a 4-entry result queue and offered from its head.
// Throughput: one item per cycle while input ready is high; an item that gives a reverse
// and a turn pushes two results. Input ready holds while the queue has two free slots.
// Reset: rst (synchronous) restores register defaults and clears search and queue state.
`default_nettype none

module line_loss_recovery_controller_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input stream.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // [11:0] adc_sample, [21:12] elapsed_ms, [23:22] zero
  input  wire logic        s_tuser,   // [0] req_type
  // Result stream.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [1:0] command, [2] turn_right, [10:3] drive_pwm,
                                      // [18:11] speed_target, [28:19] window_ms,
                                      // [29] line_found, [31:30] zero
  output logic             m_tlast,   // last_of_run
  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // Configuration registers.
  logic [11:0] low_threshold;
  logic [11:0] high_threshold;
  logic [8:0]  base_steer_ms;
  logic [7:0]  turn_drive;
  logic [7:0]  reverse_pwm;
  logic [7:0]  crawl_speed_mm_s;

  // Search state.
  logic       on_line_flag, on_line_flag_next;
  logic       last_good_side, last_good_side_next;
  logic       first_side, first_side_next;
  logic       second_try_pending, second_try_pending_next;
  logic [1:0] reversal_count, reversal_count_next;
  logic [1:0] escalated_turns, escalated_turns_next;
  logic [9:0] first_window, first_window_next;
  logic [9:0] second_window, second_window_next;
  logic       searching, searching_next;
  logic       active_side, active_side_next;
  logic [9:0] active_window, active_window_next;

  // Result queue.
  llrc_pkg::result_t              queue [llrc_pkg::QDEPTH];
  logic [llrc_pkg::PTR_W-1:0]     wr_ptr, rd_ptr;
  logic [llrc_pkg::CNT_W-1:0]     count;

  logic                   in_xfer, out_xfer, cfg_wr;
  logic [2:0]             reg_idx;
  logic                   req_type;
  logic [11:0]            sample;
  logic [9:0]             elapsed_ms;
  logic                   flag_upd;
  logic [1:0]             n_push;
  llrc_pkg::result_t      res0, res1, res_head;
  logic [10:0]            fw_sum, sw_sum;
  logic [9:0]             fw_esc;
  logic                   do_reverse;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign reg_idx = paddr[4:2];

  assign s_tready = count <= llrc_pkg::CNT_W'(llrc_pkg::QDEPTH - 2);
  assign in_xfer  = s_tvalid & s_tready;
  assign m_tvalid = count != '0;
  assign out_xfer = m_tvalid & m_tready;

  assign req_type   = s_tuser;
  assign sample     = s_tdata[11:0] & llrc_pkg::SAMPLE_MASK;
  assign elapsed_ms = s_tdata[21:12];

  assign res_head = queue[rd_ptr];
  assign m_tdata  = {2'b00, res_head.line_found, res_head.window_ms, res_head.speed_target,
                     res_head.drive_pwm, res_head.turn_right, res_head.command};
  assign m_tlast  = res_head.last_of_run;

  // Register readback.
  always_comb begin
    unique case (reg_idx)
      llrc_pkg::REG_LOW_TH:      prdata = {20'd0, low_threshold};
      llrc_pkg::REG_HIGH_TH:     prdata = {20'd0, high_threshold};
      llrc_pkg::REG_BASE_STEER:  prdata = {23'd0, base_steer_ms};
      llrc_pkg::REG_TURN_DRIVE:  prdata = {24'd0, turn_drive};
      llrc_pkg::REG_REVERSE_PWM: prdata = {24'd0, reverse_pwm};
      llrc_pkg::REG_CRAWL_SPEED: prdata = {24'd0, crawl_speed_mm_s};
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low_threshold    <= llrc_pkg::LOW_TH_RST;
      high_threshold   <= llrc_pkg::HIGH_TH_RST;
      base_steer_ms    <= llrc_pkg::BASE_STEER_RST;
      turn_drive       <= llrc_pkg::TURN_DRIVE_RST;
      reverse_pwm      <= llrc_pkg::REVERSE_PWM_RST;
      crawl_speed_mm_s <= llrc_pkg::CRAWL_SPEED_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        llrc_pkg::REG_LOW_TH:      low_threshold    <= pwdata[11:0];
        llrc_pkg::REG_HIGH_TH:     high_threshold   <= pwdata[11:0];
        llrc_pkg::REG_BASE_STEER:  base_steer_ms    <= pwdata[8:0];
        llrc_pkg::REG_TURN_DRIVE:  turn_drive       <= pwdata[7:0];
        llrc_pkg::REG_REVERSE_PWM: reverse_pwm      <= pwdata[7:0];
        llrc_pkg::REG_CRAWL_SPEED: crawl_speed_mm_s <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // The high test wins when the thresholds overlap.
  always_comb begin
    if (sample >= high_threshold) begin
      flag_upd = 1'b1;
    end else if (sample <= low_threshold) begin
      flag_upd = 1'b0;
    end else begin
      flag_upd = on_line_flag;
    end
  end

  // Item processing: next search state and up to two results.
  always_comb begin
    on_line_flag_next       = on_line_flag;
    last_good_side_next     = last_good_side;
    first_side_next         = first_side;
    second_try_pending_next = second_try_pending;
    reversal_count_next     = reversal_count;
    escalated_turns_next    = escalated_turns;
    first_window_next       = first_window;
    second_window_next      = second_window;
    searching_next          = searching;
    active_side_next        = active_side;
    active_window_next      = active_window;
    res0                    = '0;
    res1                    = '0;
    n_push                  = 2'd0;
    do_reverse              = 1'b0;
    fw_sum                  = {1'b0, first_window} + llrc_pkg::ESC_STEP;
    fw_esc                  = (fw_sum > llrc_pkg::FIRST_WIN_MAX) ?
                              llrc_pkg::FIRST_WIN_MAX[9:0] : fw_sum[9:0];
    sw_sum                  = {1'b0, fw_esc} + {1'b0, llrc_pkg::SECOND_OFFSET};

    if (req_type == llrc_pkg::REQ_POLL) begin
      // A poll with no turn running is dropped.
      if (searching) begin
        if (elapsed_ms >= active_window) begin
          searching_next   = 1'b0;
          res0.command     = llrc_pkg::CMD_STOP;
          res0.last_of_run = 1'b1;
          n_push           = 2'd1;
        end else begin
          on_line_flag_next = flag_upd;
          if (flag_upd) begin
            searching_next          = 1'b0;
            last_good_side_next     = active_side;
            second_try_pending_next = 1'b0;
            res0.command            = llrc_pkg::CMD_STOP;
            res0.line_found         = 1'b1;
            res0.last_of_run        = 1'b1;
            n_push                  = 2'd1;
          end
        end
      end
    end else begin
      on_line_flag_next = flag_upd;
      if (flag_upd) begin
        searching_next          = 1'b0;
        res0.command            = llrc_pkg::CMD_CRAWL;
        res0.speed_target       = crawl_speed_mm_s;
        res0.last_of_run        = 1'b1;
        n_push                  = 2'd1;
        first_side_next         = last_good_side;
        first_window_next       = {1'b0, base_steer_ms};
        second_window_next      = {1'b0, base_steer_ms} + llrc_pkg::SECOND_OFFSET;
        reversal_count_next     = '0;
        escalated_turns_next    = '0;
        second_try_pending_next = 1'b0;
      end else begin
        do_reverse = (reversal_count < llrc_pkg::COUNT_SAT) ||
                     (escalated_turns >= llrc_pkg::COUNT_SAT);
        if (reversal_count < llrc_pkg::COUNT_SAT) begin
          reversal_count_next = reversal_count + 2'd1;
        end
        if (!second_try_pending) begin
          active_side_next        = first_side;
          active_window_next      = first_window;
          second_try_pending_next = 1'b1;
        end else begin
          active_side_next        = ~first_side;
          active_window_next      = second_window;
          second_try_pending_next = 1'b0;
        end
        searching_next = 1'b1;

        if (reversal_count_next >= llrc_pkg::COUNT_SAT) begin
          first_window_next  = fw_esc;
          second_window_next = (sw_sum > llrc_pkg::SECOND_WIN_MAX) ?
                               llrc_pkg::SECOND_WIN_MAX[9:0] : sw_sum[9:0];
          if (escalated_turns < llrc_pkg::COUNT_SAT) begin
            escalated_turns_next = escalated_turns + 2'd1;
          end
        end

        // The turn always comes last; a reverse, when due, goes ahead of it.
        if (do_reverse) begin
          res0.command   = llrc_pkg::CMD_REVERSE;
          res0.drive_pwm = reverse_pwm;
          res1.command     = llrc_pkg::CMD_TURN;
          res1.turn_right  = active_side_next;
          res1.drive_pwm   = turn_drive;
          res1.window_ms   = active_window_next;
          res1.last_of_run = 1'b1;
          n_push           = 2'd2;
        end else begin
          res0.command     = llrc_pkg::CMD_TURN;
          res0.turn_right  = active_side_next;
          res0.drive_pwm   = turn_drive;
          res0.window_ms   = active_window_next;
          res0.last_of_run = 1'b1;
          n_push           = 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      on_line_flag       <= 1'b0;
      last_good_side     <= 1'b0;
      first_side         <= 1'b0;
      second_try_pending <= 1'b0;
      reversal_count     <= '0;
      escalated_turns    <= '0;
      first_window       <= llrc_pkg::FIRST_WIN_RST;
      second_window      <= llrc_pkg::SECOND_WIN_RST;
      searching          <= 1'b0;
      active_side        <= 1'b0;
      active_window      <= '0;
    end else if (in_xfer) begin
      on_line_flag       <= on_line_flag_next;
      last_good_side     <= last_good_side_next;
      first_side         <= first_side_next;
      second_try_pending <= second_try_pending_next;
      reversal_count     <= reversal_count_next;
      escalated_turns    <= escalated_turns_next;
      first_window       <= first_window_next;
      second_window      <= second_window_next;
      searching          <= searching_next;
      active_side        <= active_side_next;
      active_window      <= active_window_next;
    end
  end

  // Queue storage needs no reset; count and pointers gate every read.
  always_ff @(posedge clk) begin
    if (in_xfer && n_push != 2'd0) begin
      queue[wr_ptr] <= res0;
    end
    if (in_xfer && n_push == 2'd2) begin
      queue[wr_ptr + llrc_pkg::PTR_W'(1)] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (in_xfer) begin
        wr_ptr <= wr_ptr + llrc_pkg::PTR_W'(n_push);
      end
      if (out_xfer) begin
        rd_ptr <= rd_ptr + llrc_pkg::PTR_W'(1);
      end
      count <= count + (in_xfer ? llrc_pkg::CNT_W'(n_push) : '0)
                     - llrc_pkg::CNT_W'(out_xfer);
    end
  end

`include "line_loss_recovery_controller_unit_assert.svh"

  `LLRC_ASSERT_NEVER(a_queue_overflow, count > llrc_pkg::CNT_W'(llrc_pkg::QDEPTH),
                     "result queue overflow")
  `LLRC_ASSERT_NEXT(a_tick_gives_result, in_xfer && req_type == llrc_pkg::REQ_TICK,
                    m_tvalid, "decision tick left no result")
  `LLRC_ASSERT_IMP(a_escalation_order, escalated_turns != 2'd0,
                   reversal_count == llrc_pkg::COUNT_SAT,
                   "escalation before reversals saturated")
  `LLRC_ASSERT_NEVER(a_first_window_range, first_window > 10'd511,
                     "first window out of range")

endmodule

`default_nettype wire
